// ----- rtl/dspm_pkg.sv -----
`timescale 1ns / 1ps
package dspm_pkg;

  localparam int FracBitsDefault = 16;
  localparam int QueueDepth = 2;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic               spot;
  } dspm_item_t;

  // products ordered ax, bx, cx, ay, by, cy, az, bz, cz
  typedef struct packed {
    dspm_item_t                item;
    logic [8:0][31:0]          prod;
    logic signed [31:0]        d;
    logic signed [31:0]        n;
    logic signed [31:0]        nr;
  } dspm_job_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] u,
                                                input logic signed [31:0] v,
                                                input int frac);
    logic signed [63:0] p;
    p = 64'(u) * 64'(v);
    p = p + (64'sd1 <<< (frac - 1));
    p = p >>> frac;
    return sat32(p);
  endfunction

endpackage

// ----- rtl/drop_shadow_projection_matrix_unit.sv -----
`timescale 1ns / 1ps
// Datapath: nine products on one multiplier, then for parallel items a 33-step
// restoring divider for -1/n; spot items skip the divider.
// The holding register can take a new item while the front works on the last; the
// back emits one column per cycle unless out_stall holds it.
// Reset (rst, synchronous): clears the holding register, queue and output valid.
module drop_shadow_projection_matrix_unit import dspm_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] light_x,
  input  logic signed [31:0] light_y,
  input  logic signed [31:0] light_z,
  input  logic signed [31:0] plane_a,
  input  logic signed [31:0] plane_b,
  input  logic signed [31:0] plane_c,
  input  logic               spot_mode,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         column_index,
  output logic signed [31:0] entry_row0,
  output logic signed [31:0] entry_row1,
  output logic signed [31:0] entry_row2,
  output logic signed [31:0] entry_row3,
  output logic               last_column
);

  dspm_item_t item;
  dspm_job_t  push_job, head;
  logic       push, full, pop, head_valid;

  always_comb begin
    item.x = light_x;
    item.y = light_y;
    item.z = light_z;
    item.a = plane_a;
    item.b = plane_b;
    item.c = plane_c;
    item.spot = spot_mode;
  end

  dspm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_item(item),
    .push(push), .push_job(push_job), .q_full(full)
  );

  dspm_queue #(.DEPTH(QueueDepth)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_job(push_job), .full(full),
    .pop(pop), .head_valid(head_valid), .head(head)
  );

  dspm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .head_valid(head_valid), .head(head), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .column_index(column_index),
    .entry_row0(entry_row0), .entry_row1(entry_row1), .entry_row2(entry_row2),
    .entry_row3(entry_row3), .last_column(last_column)
  );

endmodule

// ----- rtl/dspm_front.sv -----
`timescale 1ns / 1ps
module dspm_front import dspm_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dspm_item_t in_item,
  output logic       push,
  output dspm_job_t  push_job,
  input  logic       q_full
);

  typedef enum logic [4:0] {
    IDLE = 5'b00001,
    MUL  = 5'b00010,
    SUM  = 5'b00100,
    DIV  = 5'b01000,
    PUSH = 5'b10000
  } state_t;

  localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC_BITS;
  localparam logic [63:0] NUM = 64'd1 << (2 * FRAC_BITS);

  state_t             state;
  dspm_item_t         hold;
  logic               hold_valid;
  dspm_item_t         w;
  logic [3:0]         k;
  logic [8:0][31:0]   prod;
  logic signed [31:0] d, n;
  logic [31:0]        mag;
  logic [63:0]        dvd;
  logic [31:0]        rem;
  logic [32:0]        q;
  logic               ovf;
  logic [5:0]         cnt;
  logic signed [31:0] u, v;
  logic signed [33:0] s;
  logic signed [31:0] n_sat;
  logic [31:0]        mag_next;
  logic [63:0]        dvd_next;
  logic [32:0]        t;
  logic [32:0]        qc;
  logic signed [31:0] nr;

  assign in_stall = hold_valid;

  always_comb begin
    case (k)
      4'd0: begin u = w.a; v = w.x; end
      4'd1: begin u = w.b; v = w.x; end
      4'd2: begin u = w.c; v = w.x; end
      4'd3: begin u = w.a; v = w.y; end
      4'd4: begin u = w.b; v = w.y; end
      4'd5: begin u = w.c; v = w.y; end
      4'd6: begin u = w.a; v = w.z; end
      4'd7: begin u = w.b; v = w.z; end
      4'd8: begin u = w.c; v = w.z; end
      default: begin u = w.a; v = w.x; end
    endcase
  end

  always_comb begin
    s = 34'(signed'(prod[0])) + 34'(signed'(prod[4])) + 34'(signed'(prod[8]));
    n_sat = sat32(64'(s));
    if (n_sat == 32'sd0) n_sat = 32'sd1;
    mag_next = n_sat[31] ? 32'(-33'(n_sat)) : 32'(n_sat);
    dvd_next = NUM + 64'(mag_next >> 1);
    t = {rem, dvd[cnt]};
    qc = (ovf || q > 33'h100000000) ? 33'h100000000 : q;
    if (n > 32'sd0) nr = (qc > 33'h080000000) ? 32'sh80000000 : 32'(-qc);
    else nr = (qc > 33'h07fffffff) ? 32'sh7fffffff : qc[31:0];
  end

  assign push = (state == PUSH) && !q_full;
  always_comb begin
    push_job.item = w;
    push_job.prod = prod;
    push_job.d = d;
    push_job.n = n;
    push_job.nr = nr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      hold_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        hold <= in_item;
        hold_valid <= 1'b1;
      end
      case (state)
        IDLE: begin
          if (hold_valid) begin
            w <= hold;
            hold_valid <= 1'b0;
            k <= 4'd0;
            state <= MUL;
          end
        end
        MUL: begin
          prod[k] <= fx_mul(u, v, FRAC_BITS);
          if (k == 4'd8) state <= SUM;
          else k <= k + 4'd1;
        end
        SUM: begin
          d <= sat32(64'(ONE - s));
          n <= n_sat;
          mag <= mag_next;
          dvd <= dvd_next;
          rem <= {1'b0, dvd_next[63:33]};
          ovf <= {1'b0, dvd_next[63:33]} >= mag_next;
          q <= '0;
          cnt <= 6'd32;
          state <= w.spot ? PUSH : DIV;
        end
        DIV: begin
          if (t >= {1'b0, mag}) begin
            rem <= 32'(t - {1'b0, mag});
            q <= {q[31:0], 1'b1};
          end else begin
            rem <= t[31:0];
            q <= {q[31:0], 1'b0};
          end
          if (cnt == 6'd0) state <= PUSH;
          else cnt <= cnt - 6'd1;
        end
        PUSH: begin
          if (!q_full) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/dspm_queue.sv -----
`timescale 1ns / 1ps
module dspm_queue import dspm_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  dspm_job_t push_job,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output dspm_job_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  dspm_job_t         mem [DEPTH];
  logic [AW-1:0]     wp, rp;
  logic [AW:0]       count;

  assign full = (count == (AW+1)'(DEPTH));
  assign head_valid = (count != '0);
  assign head = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) begin
        mem[wp] <= push_job;
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      end
      if (pop) rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// ----- rtl/dspm_back.sv -----
`timescale 1ns / 1ps
module dspm_back import dspm_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  dspm_job_t          head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         column_index,
  output logic signed [31:0] entry_row0,
  output logic signed [31:0] entry_row1,
  output logic signed [31:0] entry_row2,
  output logic signed [31:0] entry_row3,
  output logic               last_column
);

  localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC_BITS;

  logic [1:0]               col;
  logic                     a_valid, a_mul, a_last;
  logic [1:0]               a_idx;
  logic signed [31:0]       a_nr;
  logic [3:0][31:0]         a_op;
  logic [3:0][31:0]         op;
  logic signed [33:0]       kv;
  logic                     b_take, adv_a;

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] p,
                                                 input logic signed [33:0] k);
    return sat32(64'(34'(p) + k));
  endfunction

  assign b_take = !out_valid || !out_stall;
  assign adv_a = !a_valid || b_take;
  assign pop = head_valid && adv_a && (col == 2'd3);

  always_comb begin
    kv = head.item.spot ? 34'(head.d) : -34'(head.n);
    case (col)
      2'd0: begin
        op[0] = add_sat(head.prod[0], kv);
        op[1] = head.prod[1];
        op[2] = head.prod[2];
        op[3] = add_sat(32'sd0, -34'(head.item.x));
      end
      2'd1: begin
        op[0] = head.prod[3];
        op[1] = add_sat(head.prod[4], kv);
        op[2] = head.prod[5];
        op[3] = add_sat(32'sd0, -34'(head.item.y));
      end
      2'd2: begin
        op[0] = head.prod[6];
        op[1] = head.prod[7];
        op[2] = add_sat(head.prod[8], kv);
        op[3] = add_sat(32'sd0, -34'(head.item.z));
      end
      default: begin
        if (head.item.spot) begin
          op[0] = head.item.a;
          op[1] = head.item.b;
          op[2] = head.item.c;
          op[3] = add_sat(head.d, -ONE);
        end else begin
          op[0] = '0;
          op[1] = '0;
          op[2] = '0;
          op[3] = add_sat(32'sd0, -34'(head.n));
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      a_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_a) begin
        a_valid <= head_valid;
        if (head_valid) begin
          a_op <= op;
          a_mul <= !head.item.spot;
          a_nr <= head.nr;
          a_idx <= col;
          a_last <= (col == 2'd3);
          col <= col + 2'd1;
        end
      end
      if (b_take) begin
        out_valid <= a_valid;
        if (a_valid) begin
          column_index <= a_idx;
          last_column <= a_last;
          entry_row0 <= a_mul ? fx_mul(a_nr, a_op[0], FRAC_BITS) : a_op[0];
          entry_row1 <= a_mul ? fx_mul(a_nr, a_op[1], FRAC_BITS) : a_op[1];
          entry_row2 <= a_mul ? fx_mul(a_nr, a_op[2], FRAC_BITS) : a_op[2];
          entry_row3 <= a_mul ? fx_mul(a_nr, a_op[3], FRAC_BITS) : a_op[3];
        end
      end
    end
  end

endmodule

// ----- rtl/dspm_checker.sv -----
`timescale 1ns / 1ps
module dspm_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] column_index,
  input logic       last_column
);

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_column == (column_index == 2'd3)))
    else $error("last_column does not match column 3");

  a_col_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_column) |=>
      (!out_valid || column_index == $past(column_index) + 2'd1))
    else $error("column order broken");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(column_index)))
    else $error("stalled transaction changed");

endmodule

bind drop_shadow_projection_matrix_unit dspm_checker u_dspm_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .column_index(column_index), .last_column(last_column)
);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import dspm_pkg::*;

  localparam int Frac = FracBitsDefault;
  localparam int One = 1 << Frac;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [1:0]         col;
    logic signed [31:0] e0;
    logic signed [31:0] e1;
    logic signed [31:0] e2;
    logic signed [31:0] e3;
    logic               last;
  } column_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] light_x = '0, light_y = '0, light_z = '0;
  logic signed [31:0] plane_a = '0, plane_b = '0, plane_c = '0;
  logic spot_mode = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] column_index;
  logic signed [31:0] entry_row0, entry_row1, entry_row2, entry_row3;
  logic last_column;

  column_t pending_columns[$];
  int mismatches = 0;
  int columns_seen = 0;
  int items_sent = 0;
  int spot_items = 0;
  int zero_n_items = 0;
  int cycles = 0;
  bit calm = 1'b0;

  drop_shadow_projection_matrix_unit dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .light_x(light_x), .light_y(light_y), .light_z(light_z),
    .plane_a(plane_a), .plane_b(plane_b), .plane_c(plane_c),
    .spot_mode(spot_mode), .out_valid(out_valid), .out_stall(out_stall),
    .column_index(column_index), .entry_row0(entry_row0), .entry_row1(entry_row1),
    .entry_row2(entry_row2), .entry_row3(entry_row3), .last_column(last_column)
  );

  always #5 clk = ~clk;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(input longint u, input longint v);
    longint p;
    p = u * v + (64'sd1 <<< (Frac - 1));
    return clamp32(p >>> Frac);
  endfunction

  function automatic longint neg_recip(input longint n);
    longint unsigned mag, num, q;
    mag = (n < 0) ? -n : n;
    num = 64'd1 << (2 * Frac);
    q = (num + mag / 2) / mag;
    if (q > (64'd1 << 32)) q = 64'd1 << 32;
    return (n > 0) ? clamp32(-longint'(q)) : clamp32(longint'(q));
  endfunction

  task automatic predict_matrix(input logic signed [31:0] x, y, z, a, b, c,
                                input logic spot);
    longint m[4][4];
    longint ax, bx, cx, ay, by, cy, az, bz, cz, d, n, nr;
    column_t col;
    ax = qmul(a, x); bx = qmul(b, x); cx = qmul(c, x);
    ay = qmul(a, y); by = qmul(b, y); cy = qmul(c, y);
    az = qmul(a, z); bz = qmul(b, z); cz = qmul(c, z);
    if (spot) begin
      spot_items++;
      d = clamp32(One - (ax + by + cz));
      m[0][0] = clamp32(ax + d); m[1][0] = bx; m[2][0] = cx; m[3][0] = clamp32(-x);
      m[0][1] = ay; m[1][1] = clamp32(by + d); m[2][1] = cy; m[3][1] = clamp32(-y);
      m[0][2] = az; m[1][2] = bz; m[2][2] = clamp32(cz + d); m[3][2] = clamp32(-z);
      m[0][3] = a; m[1][3] = b; m[2][3] = c; m[3][3] = clamp32(d - One);
    end else begin
      n = clamp32(ax + by + cz);
      if (n == 0) begin
        n = 1;
        zero_n_items++;
      end
      nr = neg_recip(n);
      m[0][0] = qmul(nr, clamp32(ax - n)); m[1][0] = qmul(nr, bx);
      m[2][0] = qmul(nr, cx); m[3][0] = qmul(nr, clamp32(-x));
      m[0][1] = qmul(nr, ay); m[1][1] = qmul(nr, clamp32(by - n));
      m[2][1] = qmul(nr, cy); m[3][1] = qmul(nr, clamp32(-y));
      m[0][2] = qmul(nr, az); m[1][2] = qmul(nr, bz);
      m[2][2] = qmul(nr, clamp32(cz - n)); m[3][2] = qmul(nr, clamp32(-z));
      m[0][3] = 0; m[1][3] = 0; m[2][3] = 0;
      m[3][3] = qmul(nr, clamp32(-n));
    end
    for (int j = 0; j < 4; j++) begin
      col.col = j[1:0];
      col.e0 = m[0][j][31:0];
      col.e1 = m[1][j][31:0];
      col.e2 = m[2][j][31:0];
      col.e3 = m[3][j][31:0];
      col.last = (j == 3);
      pending_columns.push_back(col);
    end
  endtask

  task automatic send_light(input logic signed [31:0] x, y, z, a, b, c,
                            input logic spot);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    light_x <= x; light_y <= y; light_z <= z;
    plane_a <= a; plane_b <= b; plane_c <= c;
    spot_mode <= spot;
    in_valid <= 1'b1;
    predict_matrix(x, y, z, a, b, c, spot);
    items_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    column_t got, want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{column_index, entry_row0, entry_row1, entry_row2, entry_row3,
                last_column};
        columns_seen++;
        if (pending_columns.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected column transaction %p", got);
        end else begin
          want = pending_columns.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("column mismatch: exp %p got %p", want, got);
          end
        end
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 18);
    end
  end

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom_range(2 * One)) - One;
      2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(16 * One)) - 8 * One;
    endcase
  endfunction

  task automatic test_extremes();
    logic signed [31:0] vals[5] = '{32'sh7fffffff, 32'sh80000000, 32'sd0,
                                    32'sd1, -32'sd1};
    for (int i = 0; i < 5; i++) begin
      send_light(vals[i], vals[(i + 1) % 5], vals[(i + 2) % 5],
                 vals[(i + 3) % 5], vals[(i + 4) % 5], vals[i], 1'b1);
      send_light(vals[i], vals[(i + 2) % 5], vals[(i + 4) % 5],
                 vals[(i + 1) % 5], vals[(i + 3) % 5], vals[i], 1'b0);
    end
  endtask

  task automatic test_plain_shadow();
    send_light(0, 4 * One, 0, 0, One, 0, 1'b1);
    send_light(One, 2 * One, -One, 0, One, 0, 1'b1);
    send_light(0, -One, 0, 0, One, 0, 1'b0);
    send_light(One, -3 * One, One / 2, 0, One, 0, 1'b0);
  endtask

  task automatic test_zero_denominator();
    send_light(0, 0, 0, One, One, One, 1'b0);
    send_light(One, -One, 0, One, One, 0, 1'b0);
    send_light(5 * One, 7 * One, 0, 0, 0, One, 1'b0);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 3 && i < count / 2);
      send_light(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                 rand_word(), 1'($urandom_range(1)));
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_plain_shadow();
    test_zero_denominator();
    test_random(313);
    in_valid <= 1'b0;
    while (pending_columns.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d light transactions (%0d spot, %0d with zero plane dot), %0d columns",
             items_sent, spot_items, zero_n_items, columns_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
